[rtl/dgre_pkg.sv]
// ----------------------------------------------------------------------------
// dgre_pkg
// Shared types and constants of the directed graph reachability engine.
// ----------------------------------------------------------------------------
package dgre_pkg;

   localparam int VERTEX_W          = 4;
   localparam int COUNT_W           = 5;
   localparam int ARC_W             = 8;
   localparam int VERTEX_COUNT_INIT = 16;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_QUERY  = 2'd2,
      OP_CLEAR  = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EDIT,
      ST_SCAN,
      ST_SCAN_END,
      ST_RESP
   } state_type;

endpackage

[rtl/digraph_reachability_engine.sv]
// ----------------------------------------------------------------------------
// digraph_reachability_engine
// Directed graph held as an adjacency bit matrix with insert, remove, path
// query and clear operations, one result per operation.
// ----------------------------------------------------------------------------
// One operation is in flight at a time and each gives one result transfer.
// Clear and out-of-range operations go from accept straight to the result
// state; insert and remove pass through an edit state (row read, row write).
// A path query sweeps the adjacency rows one per cycle through the single
// read port of the row memory and merges each visited row into the visited
// map; sweeps repeat until one adds nothing. Writing vertex_count clears
// the graph. Reset and clear need no sweep: rows carry valid flags.
// ----------------------------------------------------------------------------
module digraph_reachability_engine #(
   parameter int MAX_VERTICES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_opcode,
   input  logic [dgre_pkg::VERTEX_W-1:0] req_source_vertex,
   input  logic [dgre_pkg::VERTEX_W-1:0] req_dest_vertex,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_reachable,
   output logic [dgre_pkg::ARC_W-1:0]    rsp_arc_total,
   output logic                          rsp_status,
   input  logic                          csr_write_enable,
   input  logic [dgre_pkg::COUNT_W-1:0]  csr_write_data
);

   localparam int IDX_W  = $clog2(MAX_VERTICES);
   localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
   localparam int WIDE_W = CNT_W + dgre_pkg::VERTEX_W;
   localparam int LIVE_INIT = (dgre_pkg::VERTEX_COUNT_INIT > MAX_VERTICES) ?
                              MAX_VERTICES : dgre_pkg::VERTEX_COUNT_INIT;

   dgre_pkg::state_type           state_ff, state_in;
   dgre_pkg::opcode_type          op_ff, op_in;
   logic [dgre_pkg::VERTEX_W-1:0] src_ff, src_in;
   logic [dgre_pkg::VERTEX_W-1:0] dst_ff, dst_in;
   logic [CNT_W-1:0]              live_count_ff, live_count_in;
   logic [dgre_pkg::ARC_W-1:0]    arc_cnt_ff, arc_cnt_in;
   logic [MAX_VERTICES-1:0]       visited_ff, visited_in;
   logic [IDX_W-1:0]              ptr_ff, ptr_in;
   logic                          changed_ff, changed_in;
   logic                          scan_vld_ff, scan_vld_in;
   logic [IDX_W-1:0]              scan_idx_ff, scan_idx_in;
   logic                          reach_ff, reach_in;
   logic                          status_ff, status_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_reach_ff, rsp_reach_in;
   logic                          rsp_status_ff, rsp_status_in;
   logic [dgre_pkg::ARC_W-1:0]    rsp_total_ff, rsp_total_in;

   logic                          mem_clear;
   logic [IDX_W-1:0]              mem_rd_addr;
   logic [MAX_VERTICES-1:0]       mem_rd_row;
   logic                          mem_wr_en;
   logic [MAX_VERTICES-1:0]       mem_wr_row;

   logic [WIDE_W-1:0]             req_src_wide, req_dst_wide, live_wide;
   logic [WIDE_W-1:0]             src_wide, dst_wide;
   logic [IDX_W-1:0]              req_src_idx, src_idx, dst_idx;
   logic [CNT_W-1:0]              live_last_wide;
   logic [IDX_W-1:0]              live_last;
   logic                          out_of_range;
   logic [MAX_VERTICES-1:0]       merged;
   logic                          grew;
   logic                          arc_bit;
   logic [MAX_VERTICES-1:0]       src_onehot;

   dgre_adj_mem #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_adj_mem (
      .clock   (clock),
      .reset   (reset),
      .clear   (mem_clear),
      .rd_addr (mem_rd_addr),
      .rd_row  (mem_rd_row),
      .wr_en   (mem_wr_en),
      .wr_addr (src_idx),
      .wr_row  (mem_wr_row)
   );

   assign req_src_wide   = WIDE_W'(req_source_vertex);
   assign req_dst_wide   = WIDE_W'(req_dest_vertex);
   assign live_wide      = WIDE_W'(live_count_ff);
   assign src_wide       = WIDE_W'(src_ff);
   assign dst_wide       = WIDE_W'(dst_ff);
   assign req_src_idx    = req_src_wide[IDX_W-1:0];
   assign src_idx        = src_wide[IDX_W-1:0];
   assign dst_idx        = dst_wide[IDX_W-1:0];
   assign live_last_wide = live_count_ff - 1'b1;
   assign live_last      = live_last_wide[IDX_W-1:0];
   assign out_of_range   = (req_src_wide >= live_wide) || (req_dst_wide >= live_wide);

   // one row merge per cycle
   assign merged  = (scan_vld_ff && visited_ff[scan_idx_ff]) ? (visited_ff | mem_rd_row)
                                                            : visited_ff;
   assign grew    = (merged != visited_ff);
   assign arc_bit = mem_rd_row[dst_idx];

   always_comb begin
      src_onehot              = '0;
      src_onehot[req_src_idx] = 1'b1;
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      src_in        = src_ff;
      dst_in        = dst_ff;
      live_count_in = live_count_ff;
      arc_cnt_in    = arc_cnt_ff;
      visited_in    = visited_ff;
      ptr_in        = ptr_ff;
      changed_in    = changed_ff;
      scan_vld_in   = 1'b0;
      scan_idx_in   = scan_idx_ff;
      reach_in      = reach_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_reach_in  = rsp_reach_ff;
      rsp_status_in = rsp_status_ff;
      rsp_total_in  = rsp_total_ff;
      req_ready     = 1'b0;
      mem_clear     = 1'b0;
      mem_rd_addr   = ptr_ff;
      mem_wr_en     = 1'b0;
      mem_wr_row    = mem_rd_row;

      case (state_ff)
         dgre_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            mem_rd_addr = req_src_idx;
            if (req_valid) begin
               op_in     = dgre_pkg::opcode_type'(req_opcode);
               src_in    = req_source_vertex;
               dst_in    = req_dest_vertex;
               reach_in  = 1'b0;
               status_in = 1'b0;
               if (op_in == dgre_pkg::OP_CLEAR) begin
                  mem_clear  = 1'b1;
                  arc_cnt_in = '0;
                  visited_in = '0;
                  state_in   = dgre_pkg::ST_RESP;
               end else if (out_of_range) begin
                  status_in = 1'b1;
                  state_in  = dgre_pkg::ST_RESP;
               end else if (op_in == dgre_pkg::OP_QUERY) begin
                  visited_in = src_onehot;
                  ptr_in     = '0;
                  changed_in = 1'b0;
                  state_in   = dgre_pkg::ST_SCAN;
               end else begin
                  state_in = dgre_pkg::ST_EDIT;
               end
            end
         end
         dgre_pkg::ST_EDIT: begin
            if (src_ff != dst_ff) begin
               if (op_ff == dgre_pkg::OP_INSERT && !arc_bit) begin
                  mem_wr_en           = 1'b1;
                  mem_wr_row[dst_idx] = 1'b1;
                  arc_cnt_in          = arc_cnt_ff + 1'b1;
               end else if (op_ff == dgre_pkg::OP_REMOVE && arc_bit) begin
                  mem_wr_en           = 1'b1;
                  mem_wr_row[dst_idx] = 1'b0;
                  arc_cnt_in          = arc_cnt_ff - 1'b1;
               end
            end
            state_in = dgre_pkg::ST_RESP;
         end
         dgre_pkg::ST_SCAN: begin
            mem_rd_addr = ptr_ff;
            scan_vld_in = 1'b1;
            scan_idx_in = ptr_ff;
            visited_in  = merged;
            changed_in  = changed_ff || grew;
            if (ptr_ff == live_last) begin
               state_in = dgre_pkg::ST_SCAN_END;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         dgre_pkg::ST_SCAN_END: begin
            visited_in = merged;
            if (changed_ff || grew) begin
               ptr_in     = '0;
               changed_in = 1'b0;
               state_in   = dgre_pkg::ST_SCAN;
            end else begin
               reach_in = merged[dst_idx];
               state_in = dgre_pkg::ST_RESP;
            end
         end
         dgre_pkg::ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_reach_in  = reach_ff;
               rsp_status_in = status_ff;
               rsp_total_in  = arc_cnt_ff;
               state_in      = dgre_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dgre_pkg::ST_IDLE;
         end
      endcase

      // graph init on a vertex count write
      if (csr_write_enable) begin
         live_count_in = (int'(csr_write_data) > MAX_VERTICES) ? CNT_W'(MAX_VERTICES)
                                                               : CNT_W'(csr_write_data);
         mem_clear     = 1'b1;
         arc_cnt_in    = '0;
         visited_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= dgre_pkg::ST_IDLE;
         live_count_ff <= CNT_W'(LIVE_INIT);
         arc_cnt_ff    <= '0;
         visited_ff    <= '0;
         scan_vld_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         live_count_ff <= live_count_in;
         arc_cnt_ff    <= arc_cnt_in;
         visited_ff    <= visited_in;
         scan_vld_ff   <= scan_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      src_ff        <= src_in;
      dst_ff        <= dst_in;
      ptr_ff        <= ptr_in;
      changed_ff    <= changed_in;
      scan_idx_ff   <= scan_idx_in;
      reach_ff      <= reach_in;
      status_ff     <= status_in;
      rsp_reach_ff  <= rsp_reach_in;
      rsp_status_ff <= rsp_status_in;
      rsp_total_ff  <= rsp_total_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_reachable = rsp_reach_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_arc_total = rsp_total_ff;

`ifndef SYNTHESIS
   a_status_not_reach: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> !rsp_reachable)
      else $error("out-of-range result reports reachable");

   a_clear_zero_count: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_opcode == dgre_pkg::OP_CLEAR) |=> (arc_cnt_ff == '0))
      else $error("arc count not zero after clear");

   a_scan_source_marked: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dgre_pkg::ST_SCAN) |-> visited_ff[src_idx])
      else $error("source vertex not marked during query");
`endif

endmodule

[rtl/dgre_adj_mem.sv]
// ----------------------------------------------------------------------------
// dgre_adj_mem
// Adjacency row memory: one write and one registered read per cycle, with a
// valid flag per row so that a clear needs no row-by-row writes.
// ----------------------------------------------------------------------------
module dgre_adj_mem #(
   parameter int MAX_VERTICES = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                clear,
   input  logic [$clog2(MAX_VERTICES)-1:0]     rd_addr,
   output logic [MAX_VERTICES-1:0]             rd_row,
   input  logic                                wr_en,
   input  logic [$clog2(MAX_VERTICES)-1:0]     wr_addr,
   input  logic [MAX_VERTICES-1:0]             wr_row
);

   logic [MAX_VERTICES-1:0] mem [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] row_valid_ff;
   logic [MAX_VERTICES-1:0] rd_data_ff;
   logic                    rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_row;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         rd_valid_ff <= row_valid_ff[rd_addr];
         if (wr_en) begin
            row_valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   assign rd_row = rd_valid_ff ? rd_data_ff : '0;

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the directed graph reachability engine. Directed
// arc edits, range limits and vertex-count extremes come first, then random
// graph traffic under several sender and receiver idling mixes. A shadow
// adjacency matrix predicts every result, and each result transfer is
// checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CYCLE_LIMIT = 1_500_000;
   localparam int TAIL_CYCLES = 300;

   typedef struct packed {
      logic                       reachable;
      logic [dgre_pkg::ARC_W-1:0] arc_total;
      logic                       status;
   } answer_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [1:0]                    req_opcode = dgre_pkg::OP_CLEAR;
   logic [dgre_pkg::VERTEX_W-1:0] req_source_vertex = '0;
   logic [dgre_pkg::VERTEX_W-1:0] req_dest_vertex = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic                          rsp_reachable;
   logic [dgre_pkg::ARC_W-1:0]    rsp_arc_total;
   logic                          rsp_status;
   logic                          csr_write_enable = 1'b0;
   logic [dgre_pkg::COUNT_W-1:0]  csr_write_data = '0;

   // shadow graph
   logic [15:0]                   arc_rows [16];
   logic [dgre_pkg::ARC_W-1:0]    arc_count;
   logic [dgre_pkg::COUNT_W-1:0]  vertex_limit;

   answer_type          pending_answers [$];
   int                  errors = 0;
   int                  cycle_count = 0;
   int                  send_idle_pct = 0;
   int                  stall_pct = 0;
   int                  op_seen [4] = '{0, 0, 0, 0};
   int                  hits = 0;
   int                  rejects = 0;
   int                  count_writes = 0;

   digraph_reachability_engine DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_source_vertex (req_source_vertex),
      .req_dest_vertex   (req_dest_vertex),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_reachable     (rsp_reachable),
      .rsp_arc_total     (rsp_arc_total),
      .rsp_status        (rsp_status),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_answers.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   function automatic void wipe_graph();
      foreach (arc_rows[v]) arc_rows[v] = '0;
      arc_count = '0;
   endfunction

   function automatic int live_vertices();
      return (vertex_limit > 5'd16) ? 16 : int'(vertex_limit);
   endfunction

   // one operation applied to the shadow graph
   function automatic answer_type graph_step(dgre_pkg::opcode_type op, logic [3:0] src,
                                             logic [3:0] dst);
      answer_type ans;
      int         live;
      logic [15:0] seen, prior;
      ans  = '0;
      live = live_vertices();
      if (op == dgre_pkg::OP_CLEAR) begin
         wipe_graph();
      end else if (src >= live || dst >= live) begin
         ans.status = 1'b1;
      end else begin
         case (op)
            dgre_pkg::OP_INSERT: begin
               if (src != dst && !arc_rows[src][dst]) begin
                  arc_rows[src][dst] = 1'b1;
                  arc_count++;
               end
            end
            dgre_pkg::OP_REMOVE: begin
               if (src != dst && arc_rows[src][dst]) begin
                  arc_rows[src][dst] = 1'b0;
                  arc_count--;
               end
            end
            default: begin
               seen = 16'd1 << src;
               do begin
                  prior = seen;
                  for (int v = 0; v < live; v++)
                     if (seen[v]) seen |= arc_rows[v];
               end while (seen != prior);
               ans.reachable = seen[dst];
            end
         endcase
      end
      ans.arc_total = arc_count;
      return ans;
   endfunction

   // prediction on request transfers, checking on result transfers
   always @(posedge clock) begin
      answer_type           want;
      dgre_pkg::opcode_type op;
      if (reset) begin
         wipe_graph();
         vertex_limit = dgre_pkg::COUNT_W'(dgre_pkg::VERTEX_COUNT_INIT);
      end else begin
         if (csr_write_enable) begin
            vertex_limit = csr_write_data;
            wipe_graph();
            count_writes++;
         end
         if (req_valid && req_ready) begin
            op   = dgre_pkg::opcode_type'(req_opcode);
            want = graph_step(op, req_source_vertex, req_dest_vertex);
            pending_answers.push_back(want);
            op_seen[op]++;
            if (want.reachable) hits++;
            if (want.status) rejects++;
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_answers.size() == 0) begin
               $error("result transfer with no operation outstanding");
               errors++;
            end else begin
               want = pending_answers.pop_front();
               if (rsp_reachable !== want.reachable) begin
                  $error("reachable: expected %0d, got %0d", want.reachable, rsp_reachable);
                  errors++;
               end
               if (rsp_arc_total !== want.arc_total) begin
                  $error("arc_total: expected %0d, got %0d", want.arc_total, rsp_arc_total);
                  errors++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  errors++;
               end
            end
         end
      end
   end

   task automatic send_op(dgre_pkg::opcode_type op, int src, int dst);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid         <= 1'b1;
      req_opcode        <= op;
      req_source_vertex <= dgre_pkg::VERTEX_W'(src);
      req_dest_vertex   <= dgre_pkg::VERTEX_W'(dst);
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   task automatic set_vertex_count(int value);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data   <= dgre_pkg::COUNT_W'(value);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic test_arc_edits();
      send_op(dgre_pkg::OP_INSERT, 0, 15);
      send_op(dgre_pkg::OP_INSERT, 15, 0);
      send_op(dgre_pkg::OP_INSERT, 0, 15);   // duplicate
      send_op(dgre_pkg::OP_INSERT, 5, 5);    // self-loop
      send_op(dgre_pkg::OP_QUERY, 0, 0);
      send_op(dgre_pkg::OP_QUERY, 15, 0);
      send_op(dgre_pkg::OP_QUERY, 0, 7);
      send_op(dgre_pkg::OP_INSERT, 7, 3);
      send_op(dgre_pkg::OP_QUERY, 3, 7);     // wrong direction
      send_op(dgre_pkg::OP_REMOVE, 5, 5);
      send_op(dgre_pkg::OP_REMOVE, 3, 7);    // missing arc
      send_op(dgre_pkg::OP_REMOVE, 0, 15);
      send_op(dgre_pkg::OP_QUERY, 0, 15);
      send_op(dgre_pkg::OP_CLEAR, 15, 15);
      send_op(dgre_pkg::OP_QUERY, 15, 0);
   endtask

   task automatic test_range_limits();
      set_vertex_count(0);
      send_op(dgre_pkg::OP_INSERT, 0, 0);
      send_op(dgre_pkg::OP_QUERY, 0, 0);
      send_op(dgre_pkg::OP_CLEAR, 0, 0);
      set_vertex_count(1);
      send_op(dgre_pkg::OP_INSERT, 0, 0);
      send_op(dgre_pkg::OP_QUERY, 0, 0);
      send_op(dgre_pkg::OP_INSERT, 0, 1);
      send_op(dgre_pkg::OP_QUERY, 1, 0);
      set_vertex_count(31);
      send_op(dgre_pkg::OP_INSERT, 15, 14);
      send_op(dgre_pkg::OP_QUERY, 15, 14);
      send_op(dgre_pkg::OP_REMOVE, 15, 14);
   endtask

   function automatic int pick_vertex(int live);
      if (live == 0 || $urandom_range(99) < 10) return $urandom_range(15);
      return $urandom_range(live - 1);
   endfunction

   task automatic test_random_traffic(int count_value, int items, int idle, int stall);
      int live, roll, src, dst;
      set_vertex_count(count_value);
      send_idle_pct = idle;
      stall_pct     = stall;
      live          = (count_value > 16) ? 16 : count_value;
      for (int n = 0; n < items; n++) begin
         if (n == items / 2) wait_drained();
         roll = $urandom_range(99);
         src  = pick_vertex(live);
         dst  = pick_vertex(live);
         if (roll < 2) begin
            send_op(dgre_pkg::OP_CLEAR, src, dst);
         end else if (roll < 17) begin
            // chain arcs give long paths
            send_op(dgre_pkg::OP_INSERT, src, (live > 0) ? (src + 1) % live : dst);
         end else if (roll < 50) begin
            send_op(dgre_pkg::OP_INSERT, src, dst);
         end else if (roll < 68) begin
            for (int t = 0; t < 8 && src < 16 && !arc_rows[src][dst] && live > 0; t++)
               dst = $urandom_range(live - 1);
            send_op(dgre_pkg::OP_REMOVE, src, dst);
         end else begin
            send_op(dgre_pkg::OP_QUERY, src, dst);
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_arc_edits();
      test_range_limits();
      test_random_traffic(16, 112, 0, 0);
      test_random_traffic(5, 112, 0, 0);
      test_random_traffic(31, 112, 68, 0);
      test_random_traffic(3, 112, 68, 0);
      test_random_traffic(12, 112, 0, 68);
      test_random_traffic(16, 112, 0, 68);
      test_random_traffic(8, 112, 18, 18);
      test_random_traffic($urandom_range(2, 16), 112, 18, 18);
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_answers.size() != 0) begin
         $error("%0d expected results never arrived", pending_answers.size());
         errors++;
      end
      $display("%0d inserts, %0d removes, %0d path queries (%0d reachable), %0d clears",
               op_seen[dgre_pkg::OP_INSERT], op_seen[dgre_pkg::OP_REMOVE],
               op_seen[dgre_pkg::OP_QUERY], hits, op_seen[dgre_pkg::OP_CLEAR]);
      $display("%0d operations rejected as out of range across %0d vertex-count writes",
               rejects, count_writes);
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
